FILE: src/bgc_pkg.sv
package bgc_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBounce     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDoubleWin  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegShortLimit = 2'd3;

  localparam logic [CntW-1:0] BounceReset     = 16'd20;
  localparam logic [CntW-1:0] LongPressReset  = 16'd1000;
  localparam logic [CntW-1:0] DoubleWinReset  = 16'd200;
  localparam logic [CntW-1:0] ShortLimitReset = 16'd500;

  // item kinds
  localparam logic ModeTick = 1'b0;
  localparam logic ModeEdge = 1'b1;

  // phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhRelease = 2'd1;
  localparam logic [1:0] PhDouble  = 2'd2;
  localparam logic [1:0] PhLong    = 2'd3;

  typedef enum logic [2:0] {
    GestNone   = 3'd0,
    GestDouble = 3'd1,
    GestShort  = 3'd2,
    GestLongC  = 3'd3,
    GestHold   = 3'd4
  } gesture_e;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } in_t;

  typedef struct packed {
    logic [2:0]      gesture;
    logic [CntW-1:0] press_duration;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0] bounce_ticks;
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] double_window_ticks;
    logic [CntW-1:0] short_limit_ticks;
  } cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

FILE: src/bgc_core.sv
module bgc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  bgc_pkg::in_t  item_i,
  input  bgc_pkg::cfg_t cfg_i,
  output bgc_pkg::out_t res_o
);
  import bgc_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic             deb_act_q, deb_act_d;
  logic [CntW-1:0]  deb_cnt_q, deb_cnt_d;
  logic [CntW-1:0]  hold_q, hold_d;
  logic [TimeW-1:0] tick_q, tick_d;
  logic [TimeW-1:0] press_q, press_d;
  logic [TimeW-1:0] rel_q, rel_d;

  logic [CntW-1:0]  deb_inc;
  logic [CntW-1:0]  hold_inc;
  logic [TimeW-1:0] diff;
  gesture_e         gest;
  logic [CntW-1:0]  dur;

  always_comb begin
    phase_d   = phase_q;
    deb_act_d = deb_act_q;
    deb_cnt_d = deb_cnt_q;
    hold_d    = hold_q;
    tick_d    = tick_q;
    press_d   = press_q;
    rel_d     = rel_q;
    gest      = GestNone;
    dur       = '0;
    deb_inc   = sat_inc(deb_cnt_q);
    hold_inc  = (phase_q != PhIdle) ? sat_inc(hold_q) : hold_q;
    diff      = rel_q - press_q;

    if (item_i.mode == ModeEdge) begin
      deb_act_d = 1'b1;
      deb_cnt_d = '0;
    end else begin
      tick_d = tick_q + 1'b1;
      if (deb_act_q) begin
        deb_cnt_d = deb_inc;
        if (deb_inc >= cfg_i.bounce_ticks) begin
          deb_act_d = 1'b0;
          deb_cnt_d = '0;
          // debounced pin evaluation, active low
          if (!item_i.pin_level) begin
            if (phase_q == PhIdle || phase_q == PhLong) begin
              press_d = tick_d;
              phase_d = PhRelease;
              hold_d  = '0;
            end else if (phase_q == PhDouble) begin
              hold_d  = '0;
              phase_d = PhLong;
              gest    = GestDouble;
            end
          end else begin
            if (phase_q == PhRelease) begin
              rel_d   = tick_d;
              hold_d  = '0;
              phase_d = PhDouble;
            end else if (phase_q == PhLong) begin
              phase_d = PhIdle;
            end
          end
        end
      end else begin
        hold_d = hold_inc;
        case (phase_q)
          PhRelease: begin
            if (hold_inc > cfg_i.long_press_ticks) phase_d = PhLong;
          end
          PhDouble: begin
            if (hold_inc > cfg_i.double_window_ticks) begin
              phase_d = PhIdle;
              hold_d  = '0;
              dur     = (diff > {{(TimeW-CntW){1'b0}}, CntMax}) ? CntMax : diff[CntW-1:0];
              gest    = (diff < {{(TimeW-CntW){1'b0}}, cfg_i.short_limit_ticks}) ?
                        GestShort : GestLongC;
            end
          end
          PhLong: begin
            if (hold_inc > cfg_i.long_press_ticks) gest = GestHold;
          end
          default: ;
        endcase
      end
    end
  end

  assign res_o.gesture        = gest;
  assign res_o.press_duration = dur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      deb_act_q <= 1'b0;
      deb_cnt_q <= '0;
      hold_q    <= '0;
      tick_q    <= '0;
      press_q   <= '0;
      rel_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      deb_act_q <= deb_act_d;
      deb_cnt_q <= deb_cnt_d;
      hold_q    <= hold_d;
      tick_q    <= tick_d;
      press_q   <= press_d;
      rel_q     <= rel_d;
    end
  end

endmodule

FILE: src/button_gesture_classifier_top.sv
// channel  | direction | handshake             | beat
// ---------+-----------+-----------------------+------------------------------
// in       | input     | in_valid_i/in_ready_o | in_data_i: mode, pin_level
// out      | output    | out_valid_o/out_ready_i | out_data_o: gesture, duration
// cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one beat in, one beat out; an input beat is taken every cycle while the
// output register is empty or being drained in the same cycle
// the result appears in the cycle after acceptance, from the output register
// reset clears the classifier state, the output valid and restores register defaults
// an output stall holds in_ready_o low until the waiting beat is taken
module button_gesture_classifier_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bgc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bgc_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bgc_pkg::CntW-1:0]       cfg_data_i
);
  import bgc_pkg::*;

  cfg_t cfg_q;
  out_t res;
  out_t out_q;
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_ticks        <= BounceReset;
      cfg_q.long_press_ticks    <= LongPressReset;
      cfg_q.double_window_ticks <= DoubleWinReset;
      cfg_q.short_limit_ticks   <= ShortLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBounce:     cfg_q.bounce_ticks        <= cfg_data_i;
        RegLongPress:  cfg_q.long_press_ticks    <= cfg_data_i;
        RegDoubleWin:  cfg_q.double_window_ticks <= cfg_data_i;
        RegShortLimit: cfg_q.short_limit_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bgc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
